[rtl/core/sorted_list_insert_delete_top_defines.svh]
// Assertion macros shared by the sorted list modules.
`ifndef SORTED_LIST_INSERT_DELETE_TOP_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_TOP_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define SLI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define SLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/sli_pkg.sv]
// Package with the types and constants of the sorted list block.
package sli_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DELETED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic search;
    logic commit;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  entry_count;
    logic [VAL_W-1:0]  smallest;
  } result_t;

endpackage

[rtl/core/sli_channels.sv]
// Request and result channel interfaces of the sorted list block.
interface sli_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [sli_pkg::VAL_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

interface sli_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [sli_pkg::POS_W-1:0]     position;
  logic [sli_pkg::POS_W-1:0]     entry_count;
  logic signed [sli_pkg::VAL_W-1:0] smallest;

  modport source (output valid, output status, output position, output entry_count,
                  output smallest, input ready);
  modport sink (input valid, input status, input position, input entry_count,
                input smallest, output ready);
endinterface

[rtl/core/sorted_list_insert_delete_top.sv]
// Top level of the bounded sorted list with insert and delete requests.
//
//   Channel  Direction  Payload
//   in_ch    sink       operation (0 insert, 1 delete), value (signed 32 bit)
//   out_ch   source     status, position, entry_count, smallest
//
// A request passes through three steps: capture, a parallel compare of every held
// entry against the operand, and the commit that shifts the store by one place.
// The commit waits while the previous result is still held in the output
// register, so a stalled result consumer holds the block in the commit step.
// A new request is taken as soon as the commit is done, while the result
// still waits. Reset is synchronous: it clears the entry count and the
// controller, and the store contents need no clearing because only entries
// below the count are ever read.

module sorted_list_insert_delete_top (
  input logic       clk,
  input logic       rst_n,
  sli_in_if.sink    in_ch,
  sli_out_if.source out_ch
);

  sli_pkg::cmd_t    cmd;
  sli_pkg::result_t result;
  logic             in_ready;
  logic             out_valid;

  // The controller sequences each request; the datapath holds the store.
  sli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  sli_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_operation (in_ch.operation),
    .in_value     (in_ch.value),
    .result       (result)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.status      = result.status;
  assign out_ch.position    = result.position;
  assign out_ch.entry_count = result.entry_count;
  assign out_ch.smallest    = result.smallest;

endmodule

[rtl/core/sli_ctrl.sv]
// Controller state machine of the sorted list block.
`include "sorted_list_insert_delete_top_defines.svh"

module sli_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output sli_pkg::cmd_t cmd
);

  sli_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  // The result register is free when empty or being emptied this cycle.
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sli_pkg::S_IDLE: begin
        if (in_valid) state_nxt = sli_pkg::S_SEARCH;
      end
      sli_pkg::S_SEARCH: state_nxt = sli_pkg::S_COMMIT;
      sli_pkg::S_COMMIT: begin
        if (slot_free) state_nxt = sli_pkg::S_IDLE;
      end
      default: state_nxt = sli_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      sli_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      sli_pkg::S_SEARCH: cmd.search = 1'b1;
      sli_pkg::S_COMMIT: cmd.commit = slot_free;
      default: ;
    endcase
  end

  assign out_valid_nxt = cmd.commit ? 1'b1 : (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sli_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SLI_ASSERT_NEXT(a_accept_goes_search, in_valid && in_ready, state_r == sli_pkg::S_SEARCH, "accepted request did not start search")
  `SLI_ASSERT_SAME(a_commit_needs_slot, cmd.commit, !out_valid_r || out_ready, "result overwritten before it was taken")
  `SLI_ASSERT_NEXT(a_valid_from_commit, !out_valid_r && !cmd.commit, !out_valid_r, "result appeared without a commit")

endmodule

[rtl/core/sli_datapath.sv]
// Sorted register store, search masks and result register of the sorted list block.
`include "sorted_list_insert_delete_top_defines.svh"

module sli_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sli_pkg::cmd_t                    cmd,
  input  logic                             in_operation,
  input  logic signed [sli_pkg::VAL_W-1:0] in_value,
  output sli_pkg::result_t                 result
);

  logic signed [sli_pkg::VAL_W-1:0] entries_r   [sli_pkg::CAPACITY];
  logic signed [sli_pkg::VAL_W-1:0] entries_nxt [sli_pkg::CAPACITY];
  logic [sli_pkg::CNT_W-1:0]        count_r, count_nxt;
  sli_pkg::op_t                     op_r;
  logic signed [sli_pkg::VAL_W-1:0] value_r;
  sli_pkg::status_t                 status_r, status_nxt;
  logic [sli_pkg::CNT_W-1:0]        pos_r, pos_nxt;
  sli_pkg::result_t                 result_r;

  logic [sli_pkg::CAPACITY-1:0] le_mask, lt_mask, eq_mask;
  logic                         full;

  // Each held entry compares against the operand in parallel. Because the
  // store is sorted, the masks are thermometer codes and their population
  // counts give the insert place and the first place of an equal entry.
  always_comb begin
    for (int i = 0; i < sli_pkg::CAPACITY; i++) begin
      le_mask[i] = (sli_pkg::CNT_W'(i) < count_r) && (entries_r[i] <= value_r);
      lt_mask[i] = (sli_pkg::CNT_W'(i) < count_r) && (entries_r[i] <  value_r);
      eq_mask[i] = (sli_pkg::CNT_W'(i) < count_r) && (entries_r[i] == value_r);
    end
  end

  assign full = (count_r == sli_pkg::CNT_W'(sli_pkg::CAPACITY));

  always_comb begin
    pos_nxt    = '0;
    status_nxt = sli_pkg::ST_NOT_FOUND;
    if (op_r == sli_pkg::OP_INSERT) begin
      if (full) begin
        status_nxt = sli_pkg::ST_FULL;
      end else begin
        status_nxt = sli_pkg::ST_INSERTED;
        pos_nxt    = sli_pkg::CNT_W'($countones(le_mask));
      end
    end else if (|eq_mask) begin
      status_nxt = sli_pkg::ST_DELETED;
      pos_nxt    = sli_pkg::CNT_W'($countones(lt_mask));
    end
  end

  // Per-cell update: take the lower neighbor on insert above the place,
  // the upper neighbor on delete at or above the place.
  for (genvar g = 0; g < sli_pkg::CAPACITY; g++) begin : g_cell
    logic signed [sli_pkg::VAL_W-1:0] below, above;
    if (g == 0) begin : g_lo
      assign below = value_r;
    end else begin : g_mid
      assign below = entries_r[g-1];
    end
    if (g == sli_pkg::CAPACITY - 1) begin : g_hi
      assign above = entries_r[g];
    end else begin : g_top
      assign above = entries_r[g+1];
    end
    always_comb begin
      entries_nxt[g] = entries_r[g];
      if (status_r == sli_pkg::ST_INSERTED) begin
        if (sli_pkg::CNT_W'(g) == pos_r) begin
          entries_nxt[g] = value_r;
        end else if (sli_pkg::CNT_W'(g) > pos_r) begin
          entries_nxt[g] = below;
        end
      end else if (status_r == sli_pkg::ST_DELETED) begin
        if (sli_pkg::CNT_W'(g) >= pos_r) entries_nxt[g] = above;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (status_r == sli_pkg::ST_INSERTED) begin
      count_nxt = count_r + sli_pkg::CNT_W'(1);
    end else if (status_r == sli_pkg::ST_DELETED) begin
      count_nxt = count_r - sli_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= sli_pkg::op_t'(in_operation);
      value_r <= in_value;
    end
    if (cmd.search) begin
      status_r <= status_nxt;
      pos_r    <= pos_nxt;
    end
    if (cmd.commit) begin
      entries_r            <= entries_nxt;
      result_r.status      <= status_r;
      result_r.position    <= sli_pkg::POS_W'(pos_r);
      result_r.entry_count <= sli_pkg::POS_W'(count_nxt);
      result_r.smallest    <= (count_nxt != '0) ? entries_nxt[0] : '0;
    end
  end

  assign result = result_r;

  `SLI_ASSERT_SAME(a_count_bound, 1'b1, count_r <= sli_pkg::CNT_W'(sli_pkg::CAPACITY), "entry count above capacity")
  `SLI_ASSERT_NEXT(a_insert_grows, cmd.commit && status_r == sli_pkg::ST_INSERTED, count_r == $past(count_r) + sli_pkg::CNT_W'(1), "insert did not grow the store")
  `SLI_ASSERT_NEXT(a_refuse_keeps, cmd.commit && (status_r == sli_pkg::ST_FULL || status_r == sli_pkg::ST_NOT_FOUND), count_r == $past(count_r), "refused request changed the count")

endmodule

[verif/tb.sv]
// Testbench of the bounded sorted list: random and directed insert and delete requests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Longest stretch of cycles without any handshake before the run is
  // declared hung. It lies well above the long receiver hold-off below,
  // and above what a single request needs.
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AFTER = 400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_GAP = 18;

  localparam logic signed [sli_pkg::VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic signed [sli_pkg::VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;

  // One request as the stimulus generator queues it. The gap is the number
  // of idle cycles before it is offered. When hold_for_drain is set, the
  // sender also waits until every earlier request has produced its result.
  typedef struct {
    sli_pkg::op_t                     op;
    logic signed [sli_pkg::VAL_W-1:0] value;
    int unsigned                      gap;
    bit                               hold_for_drain;
  } request_t;

  logic clk;
  logic rst_n;

  sli_in_if  in_if ();
  sli_out_if out_if ();

  sorted_list_insert_delete_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Predictor state: its own copy of the sorted store and its fill level.
  logic signed [sli_pkg::VAL_W-1:0] list_vals [sli_pkg::CAPACITY];
  int unsigned                      held;

  request_t          pending_q [$];
  sli_pkg::result_t  result_q [$];
  int unsigned       total_requests;
  int unsigned       accepted_cnt;
  int unsigned       results_seen;
  int unsigned       err_count;

  // Applies one request to the predictor's store and returns the result
  // the block must produce for it.
  function automatic sli_pkg::result_t apply_request(sli_pkg::op_t op,
                                                     logic signed [sli_pkg::VAL_W-1:0] v);
    sli_pkg::result_t r;
    int               slot;
    int               i;
    slot = 0;
    r.position = '0;
    if (op == sli_pkg::OP_INSERT) begin
      if (held >= sli_pkg::CAPACITY) begin
        r.status = sli_pkg::ST_FULL;
      end else begin
        // The new value goes after every entry that is less or equal.
        while (slot < held && list_vals[slot] <= v) slot++;
        for (i = held; i > slot; i--) list_vals[i] = list_vals[i-1];
        list_vals[slot] = v;
        held++;
        r.status = sli_pkg::ST_INSERTED;
        r.position = sli_pkg::POS_W'(slot);
      end
    end else begin
      // Only the lowest-indexed equal entry is a candidate.
      while (slot < held && list_vals[slot] < v) slot++;
      if (slot < held && list_vals[slot] == v) begin
        for (i = slot; i + 1 < held; i++) list_vals[i] = list_vals[i+1];
        held--;
        r.status = sli_pkg::ST_DELETED;
        r.position = sli_pkg::POS_W'(slot);
      end else begin
        r.status = sli_pkg::ST_NOT_FOUND;
      end
    end
    r.entry_count = sli_pkg::POS_W'(held);
    r.smallest = (held > 0) ? list_vals[0] : '0;
    return r;
  endfunction

  function automatic void queue_request(sli_pkg::op_t op, logic signed [sli_pkg::VAL_W-1:0] v,
                                        int unsigned gap, bit drain);
    request_t rq;
    rq.op = op;
    rq.value = v;
    rq.gap = gap;
    rq.hold_for_drain = drain;
    pending_q.push_back(rq);
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Reset is held at the start of the run; the sender and the receiver
  // drive their own signals low while it lasts.
  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Sender. A request is offered after its gap has run out. Acceptance is
  // seen on the pre-edge values, so the predictor is updated in the same
  // order as the block takes requests. When the next request has no gap,
  // valid simply stays high.
  int unsigned gap_left;
  bit          gap_armed;

  always @(posedge clk) begin
    bit offering;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.operation <= 1'b0;
      in_if.value <= '0;
      gap_left = 0;
      gap_armed = 1'b0;
      held = 0;
      accepted_cnt = 0;
    end else begin
      offering = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        result_q.push_back(apply_request(sli_pkg::op_t'(in_if.operation), in_if.value));
        accepted_cnt++;
        offering = 1'b0;
      end
      if (!offering && pending_q.size() > 0) begin
        if (!gap_armed) begin
          gap_left = pending_q[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!pending_q[0].hold_for_drain || results_seen == accepted_cnt) begin
          // results_seen is written with a nonblocking assignment, so this
          // compare sees the count from before the edge, whatever the order.
          in_if.operation <= pending_q[0].op;
          in_if.value <= pending_q[0].value;
          void'(pending_q.pop_front());
          gap_armed = 1'b0;
          offering = 1'b1;
        end
      end
      in_if.valid <= offering;
    end
  end

  // Receiver. After each result, ready drops for a random number of
  // cycles, except in quiet stretches. Once, a long hold-off lets the block
  // back up while the sender keeps offering requests.
  int unsigned stall_left;
  int unsigned hold_left;

  always @(posedge clk) begin
    bit               rdy;
    sli_pkg::result_t want;
    bit               quiet;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      results_seen <= 0;
      stall_left = 0;
      hold_left = 0;
      err_count = 0;
    end else begin
      rdy = out_if.ready;
      if (out_if.valid && out_if.ready) begin
        if (result_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("result %0d arrived with no request outstanding", results_seen);
        end else begin
          want = result_q.pop_front();
          if (out_if.status !== want.status || out_if.position !== want.position ||
              out_if.entry_count !== want.entry_count ||
              out_if.smallest !== want.smallest) begin
            err_count++;
            if (err_count <= 10)
              $display("result %0d: expected status %0d pos %0d count %0d smallest %0d, got status %0d pos %0d count %0d smallest %0d",
                       results_seen, want.status, want.position, want.entry_count,
                       want.smallest, out_if.status, out_if.position,
                       out_if.entry_count, out_if.smallest);
          end
        end
        results_seen <= results_seen + 1;
        quiet = ((results_seen / 100) % 3 == 1);
        stall_left = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (results_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
        rdy = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!rdy) begin
        if (stall_left > 0) stall_left--;
        else rdy = 1'b1;
      end
      out_if.ready <= rdy;
    end
  end

  // Watchdog: any cycle with a handshake on either channel resets the count.
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("no handshake for %0d cycles", IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Stimulus and end of run.
  initial begin : stimulus
    logic signed [sli_pkg::VAL_W-1:0] pool [6];
    logic signed [sli_pkg::VAL_W-1:0] val;
    int unsigned                      ins_pct;
    bit                               quiet;
    sli_pkg::op_t                     op;
    int                               k;
    int                               phase;

    // Directed part. A delete on the empty store, both extremes, zero and
    // values around it, and three equal values. Then a delete of the first
    // of the equal ones, a miss that falls between held entries, removal of
    // the head and of the tail.
    queue_request(sli_pkg::OP_DELETE, 32'sd0, 0, 1'b0);
    queue_request(sli_pkg::OP_INSERT, VAL_MAX, 0, 1'b0);
    queue_request(sli_pkg::OP_INSERT, VAL_MIN, 0, 1'b0);
    queue_request(sli_pkg::OP_INSERT, 32'sd0, 0, 1'b0);
    queue_request(sli_pkg::OP_INSERT, -32'sd1, 3, 1'b0);
    queue_request(sli_pkg::OP_INSERT, 32'sd1, 0, 1'b0);
    queue_request(sli_pkg::OP_INSERT, 32'sd7, 0, 1'b0);
    queue_request(sli_pkg::OP_INSERT, 32'sd7, 5, 1'b0);
    queue_request(sli_pkg::OP_INSERT, 32'sd7, 0, 1'b0);
    queue_request(sli_pkg::OP_DELETE, 32'sd7, 0, 1'b0);
    queue_request(sli_pkg::OP_DELETE, 32'sd3, 0, 1'b0);
    queue_request(sli_pkg::OP_DELETE, VAL_MIN, 0, 1'b0);
    queue_request(sli_pkg::OP_DELETE, VAL_MAX, 0, 1'b0);
    // Fill the store to capacity, with one more equal zero among the values,
    // and then offer one insert too many.
    for (k = 0; k < 11; k++) queue_request(sli_pkg::OP_INSERT, (k - 5) * 1000, 0, 1'b0);
    queue_request(sli_pkg::OP_INSERT, VAL_MAX, 0, 1'b0);

    // Random part in phases. Each phase has its own mix of inserts and
    // deletes, so the store swings between empty and full, and a small pool
    // of values so that deletes hit held entries and equal values pile up.
    // The first phase and one phase in the middle start only after every
    // earlier result has come back.
    for (phase = 0; phase < 25; phase++) begin
      case ($urandom_range(0, 4))
        0: ins_pct = 10;
        1: ins_pct = 30;
        2: ins_pct = 50;
        3: ins_pct = 70;
        default: ins_pct = 90;
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      for (k = 0; k < 6; k++) begin
        case ($urandom_range(0, 5))
          0: pool[k] = VAL_MIN;
          1: pool[k] = VAL_MAX;
          2: pool[k] = int'($urandom_range(0, 8)) - 4;
          default: pool[k] = $urandom;
        endcase
      end
      for (k = 0; k < 60; k++) begin
        op = ($urandom_range(0, 99) < ins_pct) ? sli_pkg::OP_INSERT : sli_pkg::OP_DELETE;
        if ($urandom_range(0, 7) == 0) val = $urandom;
        else val = pool[$urandom_range(0, 5)];
        queue_request(op, val, quiet ? 0 : $urandom_range(0, MAX_GAP),
                      k == 0 && (phase == 0 || phase == 12));
      end
    end
    total_requests = pending_q.size();

    // Counters are read on the falling edge, away from the edge that
    // updates them.
    while (!(accepted_cnt == total_requests && results_seen == total_requests))
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_count == 0 && result_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sorted_list_insert_delete_top.f]
+incdir+rtl/core
rtl/core/sli_pkg.sv
rtl/core/sli_channels.sv
rtl/core/sli_ctrl.sv
rtl/core/sli_datapath.sv
rtl/core/sorted_list_insert_delete_top.sv
verif/tb.sv
